/* sv/akc_pkg.sv */
// Shared widths, codes and control types for the aligned kernel convolution.
`timescale 1ns / 1ps

package akc_pkg;

  // Field widths of the item and result beats.
  localparam int MODE_W   = 2;
  localparam int KIDX_W   = 10;
  localparam int COEF_W   = 18;
  localparam int SAMP_W   = 32;
  localparam int VALUE_W  = 48;
  localparam int OIDX_W   = 10;

  // Configuration register widths.
  localparam int NP_W     = 11;
  localparam int ZI_W     = 10;
  localparam int CFG_W    = 11;
  localparam int CFG_IDX_W = 1;

  // Sample position counter and its saturation point.
  localparam int COUNT_W  = 12;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  // Kernel is Q0.17, so the exact sum is scaled down by 17 bits.
  localparam int FRAC     = 17;
  localparam int PROD_W   = COEF_W + SAMP_W;

  localparam int DEF_MAX_POINTS = 1024;
  localparam logic [NP_W-1:0] NP_RESET = 11'd1024;
  localparam logic [ZI_W-1:0] ZI_RESET = 10'd0;

  // Item modes.
  localparam logic [MODE_W-1:0] MODE_KERNEL = 2'd0;
  localparam logic [MODE_W-1:0] MODE_SAMPLE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_FLUSH  = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_NUM_POINTS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_ZERO_INDEX = 1'b1;

  // Control from the sequencer to the multiply-accumulate unit.
  typedef struct packed {
    logic start;
    logic tap_valid;
  } akc_mac_ctl_t;

endpackage

/* sv/akc_ram.sv */
// Simple dual-port synchronous memory with a registered read port.
`timescale 1ns / 1ps

module akc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

/* sv/akc_mac.sv */
// Pipelined multiply-accumulate unit shared by all taps of one result.
`timescale 1ns / 1ps

module akc_mac import akc_pkg::*; #(
  parameter int ACC_W = PROD_W + 10
) (
  input  logic                     clk,
  input  logic                     rst,
  input  akc_mac_ctl_t             ctl,
  input  logic signed [COEF_W-1:0] coef,
  input  logic signed [SAMP_W-1:0] samp,
  output logic                     busy,
  output logic signed [ACC_W-1:0]  acc
);

  logic                     rd_v;
  logic                     prod_v;
  logic signed [PROD_W-1:0] prod;

  // Memory data arrives in the cycle after the tap is issued.
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_v   <= 1'b0;
      prod_v <= 1'b0;
    end else begin
      rd_v   <= ctl.tap_valid;
      prod_v <= rd_v;
    end
  end

  // Product register.
  always_ff @(posedge clk) begin
    prod <= PROD_W'(coef) * PROD_W'(samp);
  end

  // Exact accumulation, cleared at the start of each result.
  always_ff @(posedge clk) begin
    if (ctl.start) begin
      acc <= '0;
    end else if (prod_v) begin
      acc <= acc + ACC_W'(prod);
    end
  end

  assign busy = rd_v | prod_v;

endmodule

/* sv/aligned_kernel_convolution.sv */
// Top level: item sequencer, kernel and sample memories, and result register.
// Kernel beats, flush or sample beats that give no result are taken without a tap walk.
// A beat that gives a result walks its m valid taps (m at most the length in use)
// through one memory read port each and the shared multiplier before the next beat is taken.
// The result register frees the input side while a result waits to be taken.
// Reset clears control state and the sample position; the memories are not cleared.
`timescale 1ns / 1ps

module aligned_kernel_convolution import akc_pkg::*; #(
  parameter int MAX_POINTS = DEF_MAX_POINTS
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [MODE_W-1:0]         mode,
  input  logic [KIDX_W-1:0]         kernel_index,
  input  logic signed [COEF_W-1:0]  coefficient,
  input  logic signed [SAMP_W-1:0]  sample,
  input  logic                      first_of_spectrum,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic signed [VALUE_W-1:0] value,
  output logic [OIDX_W-1:0]         out_index,
  output logic                      last,
  input  logic                      cfg_write,
  input  logic [CFG_IDX_W-1:0]      cfg_index,
  input  logic [CFG_W-1:0]          cfg_data
);

  localparam int AW    = $clog2(MAX_POINTS);
  localparam int ACC_W = PROD_W + AW;
  localparam logic [COUNT_W:0] MAX_LEN = (COUNT_W + 1)'(MAX_POINTS);

  typedef enum logic [1:0] {
    IDLE,
    RUN,
    DRAIN
  } state_t;

  state_t                   state;
  logic [NP_W-1:0]          num_points;
  logic [ZI_W-1:0]          zero_index;
  logic [COUNT_W-1:0]       sample_count;
  logic [COUNT_W-1:0]       k;
  logic [COUNT_W-1:0]       khi;
  logic [COUNT_W-1:0]       pos;
  logic [COUNT_W-1:0]       res_i;

  logic [COUNT_W-1:0]       n_len;
  logic                     accept;
  logic                     is_samp;
  logic                     saturated;
  logic [COUNT_W-1:0]       p;
  logic [COUNT_W-1:0]       i_pos;
  logic                     emit;
  logic [COUNT_W-1:0]       klo_next;
  logic [COUNT_W-1:0]       khi_next;
  logic                     kern_we;
  logic                     samp_we;
  logic [SAMP_W-1:0]        samp_wdata;
  logic [COUNT_W-1:0]       samp_pos;
  logic [COEF_W-1:0]        kern_rdata;
  logic [SAMP_W-1:0]        samp_rdata;
  logic                     tap_issue;
  logic                     mac_busy;
  logic signed [ACC_W-1:0]  acc;
  logic signed [ACC_W-1:0]  acc_sh;
  logic                     out_free;
  logic                     finish;
  akc_mac_ctl_t             mac_ctl;

  // Length in use is the configured length capped at the memory depth.
  always_comb begin
    if ({{(COUNT_W + 1 - NP_W){1'b0}}, num_points} < MAX_LEN) begin
      n_len = COUNT_W'(num_points);
    end else begin
      n_len = MAX_LEN[COUNT_W-1:0];
    end
  end

  // Decode of the incoming beat.
  always_comb begin
    accept     = (state == IDLE) && in_valid;
    is_samp    = (mode == MODE_SAMPLE) || (mode == MODE_FLUSH);
    saturated  = !first_of_spectrum && (sample_count == COUNT_MAX);
    p          = first_of_spectrum ? '0 : sample_count;
    i_pos      = p - COUNT_W'(zero_index);
    emit       = is_samp && !saturated && (p >= COUNT_W'(zero_index)) && (i_pos < n_len);
    klo_next   = (p >= n_len) ? (p - n_len + 1'b1) : '0;
    khi_next   = (p < n_len - 1'b1) ? p : (n_len - 1'b1);
    kern_we    = accept && (mode == MODE_KERNEL) &&
                 ({{(COUNT_W + 1 - KIDX_W){1'b0}}, kernel_index} < MAX_LEN);
    samp_we    = accept && is_samp && !saturated && (p < n_len);
    samp_wdata = (mode == MODE_SAMPLE) ? sample : '0;
  end

  // Tap walk: kernel tap k pairs with sample position pos - k.
  always_comb begin
    tap_issue         = (state == RUN) && (k <= khi);
    samp_pos          = pos - k;
    mac_ctl.start     = accept && emit;
    mac_ctl.tap_valid = tap_issue;
  end

  akc_ram #(
    .WIDTH (COEF_W),
    .DEPTH (MAX_POINTS),
    .AW    (AW)
  ) u_kernel_ram (
    .clk   (clk),
    .we    (kern_we),
    .waddr (AW'(kernel_index)),
    .wdata (coefficient),
    .raddr (k[AW-1:0]),
    .rdata (kern_rdata)
  );

  akc_ram #(
    .WIDTH (SAMP_W),
    .DEPTH (MAX_POINTS),
    .AW    (AW)
  ) u_sample_ram (
    .clk   (clk),
    .we    (samp_we),
    .waddr (p[AW-1:0]),
    .wdata (samp_wdata),
    .raddr (samp_pos[AW-1:0]),
    .rdata (samp_rdata)
  );

  akc_mac #(
    .ACC_W (ACC_W)
  ) u_mac (
    .clk  (clk),
    .rst  (rst),
    .ctl  (mac_ctl),
    .coef (kern_rdata),
    .samp (samp_rdata),
    .busy (mac_busy),
    .acc  (acc)
  );

  // Floor scaling is an arithmetic shift of the exact sum.
  always_comb begin
    acc_sh   = acc >>> FRAC;
    out_free = !out_valid || !out_stall;
    finish   = (state == DRAIN) && !mac_busy && out_free;
  end

  assign in_stall = (state != IDLE);

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      num_points <= NP_RESET;
      zero_index <= ZI_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_NUM_POINTS: num_points <= cfg_data;
        REG_ZERO_INDEX: zero_index <= cfg_data[ZI_W-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer with the sample position and the result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= IDLE;
      sample_count <= '0;
      out_valid    <= 1'b0;
    end else begin
      case (state)
        IDLE: begin
          if (in_valid && is_samp && !saturated) begin
            sample_count <= p + 1'b1;
            if (emit) begin
              state <= RUN;
            end
          end
        end
        RUN: begin
          if (!tap_issue) begin
            state <= DRAIN;
          end
        end
        DRAIN: begin
          if (finish) begin
            state <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
      // A finished walk loads the result; otherwise a taken result clears it.
      if (finish) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Walk bounds and result payload.
  always_ff @(posedge clk) begin
    if (accept && emit) begin
      k     <= klo_next;
      khi   <= khi_next;
      pos   <= p;
      res_i <= i_pos;
    end else if (tap_issue) begin
      k <= k + 1'b1;
    end
    if (finish) begin
      value     <= VALUE_W'(acc_sh);
      out_index <= res_i[OIDX_W-1:0];
      last      <= (res_i == n_len - 1'b1);
    end
  end

`ifndef SYNTHESIS
  // The input side is held off for the whole of a tap walk.
  a_stall_busy: assert property (@(posedge clk) disable iff (rst)
    (state != IDLE) |-> in_stall)
    else $error("input accepted during a tap walk");

  // The multiply pipeline has drained before a new beat is taken.
  a_idle_drained: assert property (@(posedge clk) disable iff (rst)
    (state == IDLE) |-> !mac_busy)
    else $error("multiply pipeline busy while idle");

  // Every issued tap lies within the walk bounds and the stored samples.
  a_tap_bounds: assert property (@(posedge clk) disable iff (rst)
    tap_issue |-> (k <= pos) && (samp_pos < n_len))
    else $error("tap issued outside the valid range");

  // A result is loaded only once the previous one has been taken.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    finish |-> out_free)
    else $error("result register overwritten");
`endif

endmodule
